// ----- rtl/owrs_pkg.sv -----
package owrs_pkg;

   localparam int ROM_BITS  = 64;
   localparam int ROM_CODE_W = 64;
   localparam int POS_W     = $clog2(ROM_BITS + 1);
   localparam int IDX_W     = $clog2(ROM_BITS);
   localparam int COUNT_W   = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] MAX_DEVICES_RESET = '1;

   typedef enum logic [2:0] {
      ST_CONT    = 3'd0,
      ST_MORE    = 3'd1,
      ST_LAST    = 3'd2,
      ST_NOPRES  = 3'd3,
      ST_NORESP  = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_BIT   = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [ROM_BITS-1:0] rom;
      logic [POS_W-1:0]    last_disc;
      logic [POS_W-1:0]    pass_disc;
      logic [POS_W-1:0]    bit_cnt;
      logic                active;
      logic                done;
      logic [COUNT_W-1:0]  found;
   } search_state_type;

   typedef struct packed {
      req_kind_type kind;
      logic         new_search;
      logic         presence;
      logic         id_bit;
      logic         cmp_bit;
   } search_req_type;

   typedef struct packed {
      logic               write_bit;
      status_type         status;
      logic [POS_W-1:0]   bit_position;
   } search_rsp_type;

endpackage

// ----- rtl/owrs_step.sv -----
module owrs_step
   import owrs_pkg::*;
(
   input  search_state_type   cur,
   input  search_req_type     req,
   input  logic [COUNT_W-1:0] max_devices,
   output search_state_type   nxt,
   output search_rsp_type     rsp
);

   logic [POS_W-1:0]   pos;
   logic [IDX_W-1:0]   idx;
   logic               dir;
   logic [POS_W-1:0]   pdisc;
   logic [COUNT_W-1:0] found_new;

   always_comb begin
      nxt              = cur;
      rsp.write_bit    = 1'b0;
      rsp.status       = ST_CONT;
      rsp.bit_position = '0;
      pos              = cur.bit_cnt + POS_W'(1);
      idx              = cur.bit_cnt[IDX_W-1:0];
      dir              = 1'b0;
      pdisc            = cur.pass_disc;
      found_new        = cur.found;

      unique case (req.kind)
         REQ_START: begin
            if (req.new_search) begin
               nxt.rom       = '0;
               nxt.last_disc = '0;
               nxt.found     = '0;
               nxt.done      = 1'b0;
            end
            nxt.active = 1'b0;
            if (!nxt.done && nxt.found >= max_devices) begin
               nxt.done = 1'b1;
            end
            if (nxt.done) begin
               rsp.status = ST_IGNORED;
            end else if (!req.presence) begin
               nxt.done   = 1'b1;
               rsp.status = ST_NOPRES;
            end else begin
               nxt.active    = 1'b1;
               nxt.bit_cnt   = '0;
               nxt.pass_disc = '0;
            end
         end
         REQ_BIT: begin
            if (!cur.active || cur.bit_cnt >= POS_W'(ROM_BITS)) begin
               nxt.active = 1'b0;
               rsp.status = ST_IGNORED;
            end else begin
               nxt.bit_cnt      = pos;
               rsp.bit_position = pos;
               if (req.id_bit && req.cmp_bit) begin
                  // nobody answered: end the enumeration, ROM bit untouched
                  nxt.active = 1'b0;
                  nxt.done   = 1'b1;
                  rsp.status = ST_NORESP;
               end else begin
                  if (req.id_bit != req.cmp_bit) begin
                     dir = req.id_bit;
                  end else begin
                     // conflict: follow the old path below the last fork,
                     // take the one branch at it, zero beyond it
                     if (pos < cur.last_disc) begin
                        dir = cur.rom[idx];
                     end else begin
                        dir = (pos == cur.last_disc);
                     end
                     if (!dir) begin
                        pdisc = pos;
                     end
                  end
                  nxt.pass_disc = pdisc;
                  nxt.rom[idx]  = dir;
                  rsp.write_bit = dir;
                  if (pos == POS_W'(ROM_BITS)) begin
                     nxt.active    = 1'b0;
                     if (cur.found != COUNT_MAX) begin
                        found_new = cur.found + COUNT_W'(1);
                     end
                     nxt.found     = found_new;
                     nxt.last_disc = pdisc;
                     rsp.status    = ST_MORE;
                     if (pdisc == '0) begin
                        rsp.status = ST_LAST;
                        nxt.done   = 1'b1;
                     end
                     if (found_new >= max_devices) begin
                        nxt.done = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            rsp.status = ST_IGNORED;
         end
      endcase
   end

endmodule

// ----- rtl/one_wire_rom_search_engine.sv -----
// Responses come the cycle after the request is accepted. Throughput: one beat
// per cycle while rsp_tready is high; the search decision and the ROM register
// update finish in the accept cycle, the response waits in one output register.
// Reset (synchronous, active high): ROM, discrepancies and count cleared,
// no pass active, enumeration idle until a new search, max_devices = 255.
module one_wire_rom_search_engine
   import owrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [0] new_search, [1] presence, [2] id_bit, [3] cmp_bit
   input  logic [0:0]   req_tuser,  // [0] req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,  // [0] write_bit, [64:1] rom_code,
                                    // [72:65] device_count, [79:73] bit_position
   output logic [2:0]   rsp_tuser,  // [2:0] status
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata   // max_devices
);

   search_state_type   state_ff, state_in;
   search_req_type     req;
   search_rsp_type     step_rsp;
   logic [COUNT_W-1:0] max_dev_ff;
   logic               rsp_valid_ff;
   search_rsp_type     rsp_ff;
   logic [ROM_BITS-1:0] rom_out_ff;
   logic [COUNT_W-1:0] count_out_ff;
   logic               accept;

   assign req.kind       = req_kind_type'(req_tuser[0]);
   assign req.new_search = req_tdata[0];
   assign req.presence   = req_tdata[1];
   assign req.id_bit     = req_tdata[2];
   assign req.cmp_bit    = req_tdata[3];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   owrs_step u_step (
      .cur         (state_ff),
      .req         (req),
      .max_devices (max_dev_ff),
      .nxt         (state_in),
      .rsp         (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '{done: 1'b1, default: '0};
         max_dev_ff      <= MAX_DEVICES_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            max_dev_ff <= csr_wdata;
         end
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold until the next accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff       <= step_rsp;
         rom_out_ff   <= state_in.rom;
         count_out_ff <= state_in.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.bit_position, count_out_ff,
                        ROM_CODE_W'(rom_out_ff), rsp_ff.write_bit};
   assign rsp_tuser  = rsp_ff.status;

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no response beat");

   a_ignored_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_IGNORED) |->
         (rsp_ff.bit_position == '0 && !rsp_ff.write_bit))
      else $error("ignored beat carries a position or direction");

   a_found_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_MORE || rsp_ff.status == ST_LAST)) |->
         rsp_ff.bit_position == POS_W'(ROM_BITS))
      else $error("device reported before the last ROM bit");

   a_pass_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> state_ff.bit_cnt < POS_W'(ROM_BITS))
      else $error("active pass ran past the ROM length");

endmodule
